// File: hw/rtl/bf3_pkg.sv
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared constants, register codes, exp tables and control structs of the
// 3-D bilateral filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

  localparam int MAX_DIM          = 32;
  localparam int MAX_DIAMETER     = 7;
  localparam int DEF_VALUE_BITS   = 16;

  localparam int COORD_W = 5;
  localparam int ADDR_W  = 3 * COORD_W;
  localparam int SIZE_W  = 6;
  localparam int DIAM_W  = 3;
  localparam int COEF_W  = 24;
  localparam int FIELD_W = 16;
  localparam int CNT_W   = 4;
  localparam int DIST_W  = 5;
  localparam int WGT_W   = 17;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [DIAM_W-1:0] RST_DIAMETER = 3'd3;
  localparam logic [COEF_W-1:0] RST_RANGE    = 24'd8;
  localparam logic [COEF_W-1:0] RST_SPATIAL  = 24'd65536;
  localparam logic [SIZE_W-1:0] RST_SIZE     = 6'd32;

  typedef enum logic [2:0] {
    REG_DIAMETER = 3'd0,
    REG_RANGE    = 3'd1,
    REG_SPATIAL  = 3'd2,
    REG_SIZE_X   = 3'd3,
    REG_SIZE_Y   = 3'd4,
    REG_SIZE_Z   = 3'd5
  } reg_idx_e;

  // Effective geometry and coefficients, after saturation
  typedef struct packed {
    logic [COEF_W-1:0] range_coef;
    logic [COEF_W-1:0] spatial_coef;
    logic [SIZE_W-1:0] sx;
    logic [SIZE_W-1:0] sy;
    logic [SIZE_W-1:0] sz;
    logic [DIAM_W-1:0] diam;
    logic [DIAM_W-1:0] half;
  } cfg_t;

  typedef struct packed {
    logic wr_en;
    logic start;
    logic mod_step;
    logic rd_centre;
    logic back_step;
    logic walk_init;
    logic issue;
    logic div_init;
    logic div_step;
    logic res_ld;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic walk_last;
  } sts_t;

  // exp(-n) * 65536
  function automatic logic [WGT_W-1:0] exp_int(input logic [3:0] n);
    logic [WGT_W-1:0] r;
    unique case (n)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd24109;
      4'd2:    r = 17'd8869;
      4'd3:    r = 17'd3263;
      4'd4:    r = 17'd1200;
      4'd5:    r = 17'd442;
      4'd6:    r = 17'd162;
      4'd7:    r = 17'd60;
      4'd8:    r = 17'd22;
      4'd9:    r = 17'd8;
      4'd10:   r = 17'd3;
      4'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // exp(-h/16) * 65536
  function automatic logic [WGT_W-1:0] exp_hi(input logic [3:0] h);
    logic [WGT_W-1:0] r;
    unique case (h)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd61565;
      4'd2:  r = 17'd57835;
      4'd3:  r = 17'd54331;
      4'd4:  r = 17'd51039;
      4'd5:  r = 17'd47947;
      4'd6:  r = 17'd45042;
      4'd7:  r = 17'd42313;
      4'd8:  r = 17'd39750;
      4'd9:  r = 17'd37341;
      4'd10: r = 17'd35079;
      4'd11: r = 17'd32954;
      4'd12: r = 17'd30957;
      4'd13: r = 17'd29081;
      4'd14: r = 17'd27319;
      default: r = 17'd25664;
    endcase
    return r;
  endfunction

  // exp(-l/256) * 65536
  function automatic logic [WGT_W-1:0] exp_lo(input logic [3:0] l);
    logic [WGT_W-1:0] r;
    unique case (l)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd65280;
      4'd2:  r = 17'd65026;
      4'd3:  r = 17'd64772;
      4'd4:  r = 17'd64520;
      4'd5:  r = 17'd64268;
      4'd6:  r = 17'd64018;
      4'd7:  r = 17'd63768;
      4'd8:  r = 17'd63520;
      4'd9:  r = 17'd63272;
      4'd10: r = 17'd63025;
      4'd11: r = 17'd62780;
      4'd12: r = 17'd62535;
      4'd13: r = 17'd62291;
      4'd14: r = 17'd62048;
      default: r = 17'd61806;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/bf3_in_if.sv
// ----------------------------------------------------------------------------
// bf3_in_if
// Request channel of the filter: load or filter one voxel.
// ----------------------------------------------------------------------------
interface bf3_in_if import bf3_pkg::*;;
  logic               valid;
  logic               ready;
  logic               func;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [COORD_W-1:0] pos_z;
  logic [FIELD_W-1:0] voxel_value;

  modport source (output valid, func, pos_x, pos_y, pos_z, voxel_value, input ready);
  modport sink   (input valid, func, pos_x, pos_y, pos_z, voxel_value, output ready);
endinterface

// File: hw/rtl/bf3_out_if.sv
// ----------------------------------------------------------------------------
// bf3_out_if
// Result channel of the filter: one filtered voxel value.
// ----------------------------------------------------------------------------
interface bf3_out_if import bf3_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] filtered_value;

  modport source (output valid, filtered_value, input ready);
  modport sink   (input valid, filtered_value, output ready);
endinterface

// File: hw/rtl/bilateral_filter_3d_unit.sv
// ----------------------------------------------------------------------------
// bilateral_filter_3d_unit
// Requests: a load request writes one voxel and gives no result.
// Throughput: one request at a time; the window walk reads one voxel per
//   cycle from the single memory read port, plus a 16-step divide.
// Reset: config returns to its defaults; the voxel volume keeps no reset and
//   is undefined until written.
// ----------------------------------------------------------------------------
module bilateral_filter_3d_unit import bf3_pkg::*; #(
  parameter int VALUE_BITS = bf3_pkg::DEF_VALUE_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  bf3_in_if.sink             in_if,
  bf3_out_if.source          out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // Configuration: register i at byte address 4*i, written on the access cycle
  bf3_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: accept a request only when idle, hold the result until taken
  bf3_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_if.valid),
    .in_func_i   (in_if.func),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: volume memory, window address walk, weight pipeline, divider
  bf3_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .pos_x_i          (in_if.pos_x),
    .pos_y_i          (in_if.pos_y),
    .pos_z_i          (in_if.pos_z),
    .voxel_value_i    (in_if.voxel_value),
    .sts_o            (sts),
    .filtered_value_o (out_if.filtered_value)
  );

endmodule

// File: hw/rtl/bf3_regs.sv
// ----------------------------------------------------------------------------
// bf3_regs
// APB configuration registers with saturation of window and volume sizes.
// ----------------------------------------------------------------------------
module bf3_regs import bf3_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic [DIAM_W-1:0] diameter_q;
  logic [COEF_W-1:0] range_q, spatial_q;
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  reg_idx_e          idx;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diameter_q <= RST_DIAMETER;
      range_q    <= RST_RANGE;
      spatial_q  <= RST_SPATIAL;
      size_x_q   <= RST_SIZE;
      size_y_q   <= RST_SIZE;
      size_z_q   <= RST_SIZE;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_DIAMETER: diameter_q <= pwdata[DIAM_W-1:0];
        REG_RANGE:    range_q    <= pwdata[COEF_W-1:0];
        REG_SPATIAL:  spatial_q  <= pwdata[COEF_W-1:0];
        REG_SIZE_X:   size_x_q   <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y:   size_y_q   <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z:   size_z_q   <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DIAMETER: prdata = PDATA_W'(diameter_q);
      REG_RANGE:    prdata = PDATA_W'(range_q);
      REG_SPATIAL:  prdata = PDATA_W'(spatial_q);
      REG_SIZE_X:   prdata = PDATA_W'(size_x_q);
      REG_SIZE_Y:   prdata = PDATA_W'(size_y_q);
      REG_SIZE_Z:   prdata = PDATA_W'(size_z_q);
      default:      prdata = '0;
    endcase
  end

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) r = SIZE_W'(1);
    else if (s > SIZE_W'(MAX_DIM)) r = SIZE_W'(MAX_DIM);
    else r = s;
    return r;
  endfunction

  logic [DIAM_W-1:0] diam;
  assign diam = (diameter_q > DIAM_W'(MAX_DIAMETER)) ? DIAM_W'(MAX_DIAMETER) : diameter_q;

  assign cfg_o.range_coef   = range_q;
  assign cfg_o.spatial_coef = spatial_q;
  assign cfg_o.sx           = eff_size(size_x_q);
  assign cfg_o.sy           = eff_size(size_y_q);
  assign cfg_o.sz           = eff_size(size_z_q);
  assign cfg_o.diam         = diam;
  assign cfg_o.half         = diam >> 1;

endmodule

// File: hw/rtl/bf3_dp.sv
// ----------------------------------------------------------------------------
// bf3_dp
// Datapath: voxel memory, window walker, weight pipeline, accumulators and
// radix-2 divider.
// ----------------------------------------------------------------------------
module bf3_dp import bf3_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  input  logic [COORD_W-1:0] pos_x_i,
  input  logic [COORD_W-1:0] pos_y_i,
  input  logic [COORD_W-1:0] pos_z_i,
  input  logic [FIELD_W-1:0] voxel_value_i,
  output sts_t               sts_o,
  output logic [FIELD_W-1:0] filtered_value_o
);

  localparam int V     = VALUE_BITS;
  localparam int DSQ_W = 2 * V;
  localparam int RP_W  = DSQ_W + COEF_W;
  localparam int RA_W  = RP_W - 8;
  localparam int SA_W  = DIST_W + COEF_W;
  localparam int WV_W  = WGT_W + V;
  localparam int NUM_W = WV_W + 9;
  localparam int DEN_W = WGT_W + 9;

  // Voxel memory
  logic [V-1:0]      mem_q [2**ADDR_W];
  logic [V-1:0]      rd_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;

  logic [COORD_W-1:0] mx_q, my_q, mz_q;
  logic [COORD_W-1:0] bx_q, by_q, bz_q;
  logic [COORD_W-1:0] wx_q, wy_q, wz_q;
  logic [DIAM_W-1:0]  i_q, j_q, k_q;

  assign rd_en   = cmd_i.issue | cmd_i.rd_centre;
  assign rd_addr = cmd_i.rd_centre ? {bx_q, by_q, bz_q} : {wx_q, wy_q, wz_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[{pos_x_i, pos_y_i, pos_z_i}] <= voxel_value_i[V-1:0];
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Coordinate helpers
  function automatic logic [COORD_W-1:0] mod_bit(input logic [COORD_W-1:0] r,
                                                 input logic b,
                                                 input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] t;
    t = {r, b};
    if (t >= s) t = t - s;
    return t[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] dec_wrap(input logic [COORD_W-1:0] c,
                                                  input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] sm1;
    sm1 = s - SIZE_W'(1);
    return (c == '0) ? sm1[COORD_W-1:0] : c - COORD_W'(1);
  endfunction

  function automatic logic [COORD_W-1:0] inc_wrap(input logic [COORD_W-1:0] c,
                                                  input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] sm1;
    sm1 = s - SIZE_W'(1);
    return (SIZE_W'(c) == sm1) ? '0 : c + COORD_W'(1);
  endfunction

  function automatic logic [DIST_W-1:0] off_sq(input logic [DIAM_W-1:0] idx,
                                               input logic [DIAM_W-1:0] half);
    logic [DIAM_W-1:0]   a;
    logic [2*DIAM_W-1:0] p;
    a = (idx >= half) ? idx - half : half - idx;
    p = a * a;
    return DIST_W'(p);
  endfunction

  logic [DIAM_W-1:0] dm1;
  logic              k_end, j_end, i_end;
  logic [DIST_W-1:0] dist2;

  assign dm1   = cfg_i.diam - DIAM_W'(1);
  assign k_end = (k_q == dm1);
  assign j_end = (j_q == dm1);
  assign i_end = (i_q == dm1);
  assign dist2 = off_sq(i_q, cfg_i.half) + off_sq(j_q, cfg_i.half) + off_sq(k_q, cfg_i.half);
  assign sts_o.walk_last = k_end & j_end & i_end;

  // Centre remainder, corner back-off and window walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mx_q <= pos_x_i;
      my_q <= pos_y_i;
      mz_q <= pos_z_i;
      bx_q <= '0;
      by_q <= '0;
      bz_q <= '0;
    end else if (cmd_i.mod_step) begin
      bx_q <= mod_bit(bx_q, mx_q[COORD_W-1], cfg_i.sx);
      by_q <= mod_bit(by_q, my_q[COORD_W-1], cfg_i.sy);
      bz_q <= mod_bit(bz_q, mz_q[COORD_W-1], cfg_i.sz);
      mx_q <= mx_q << 1;
      my_q <= my_q << 1;
      mz_q <= mz_q << 1;
    end else if (cmd_i.back_step) begin
      bx_q <= dec_wrap(bx_q, cfg_i.sx);
      by_q <= dec_wrap(by_q, cfg_i.sy);
      bz_q <= dec_wrap(bz_q, cfg_i.sz);
    end
    if (cmd_i.walk_init) begin
      wx_q <= bx_q;
      wy_q <= by_q;
      wz_q <= bz_q;
      i_q  <= '0;
      j_q  <= '0;
      k_q  <= '0;
    end else if (cmd_i.issue) begin
      if (!k_end) begin
        k_q  <= k_q + DIAM_W'(1);
        wz_q <= inc_wrap(wz_q, cfg_i.sz);
      end else begin
        k_q  <= '0;
        wz_q <= bz_q;
        if (!j_end) begin
          j_q  <= j_q + DIAM_W'(1);
          wy_q <= inc_wrap(wy_q, cfg_i.sy);
        end else begin
          j_q  <= '0;
          wy_q <= by_q;
          i_q  <= i_q + DIAM_W'(1);
          wx_q <= inc_wrap(wx_q, cfg_i.sx);
        end
      end
    end
  end

  // Weight pipeline
  logic [7:1]         v_q;
  logic               ctr_pend_q;
  logic [V-1:0]       centre_q;
  logic [DIST_W-1:0]  dist1_q;
  logic [DSQ_W-1:0]   dsq2_q;
  logic [SA_W-1:0]    sarg2_q, sarg3_q;
  logic [RA_W-1:0]    rarg3_q;
  logic [V-1:0]       val2_q, val3_q, val4_q, val5_q, val6_q;
  logic               rsat4_q, ssat4_q;
  logic [3:0]         rlo4_q, slo4_q;
  logic [WGT_W-1:0]   re4_q, se4_q, re5_q, se5_q, w6_q, w7_q;
  logic [WV_W-1:0]    wv7_q;
  logic [NUM_W-1:0]   num_q;
  logic [DEN_W-1:0]   den_q;

  logic [V-1:0]       diff;
  logic [RP_W-1:0]    rprod;
  logic [2*WGT_W-1:0] re_p1, se_p1, re_p2, se_p2, w_p;

  assign diff  = (rd_q >= centre_q) ? rd_q - centre_q : centre_q - rd_q;
  assign rprod = dsq2_q * cfg_i.range_coef;
  assign re_p1 = exp_int(rarg3_q[19:16]) * exp_hi(rarg3_q[15:12]) + (2*WGT_W)'(32768);
  assign se_p1 = exp_int(sarg3_q[19:16]) * exp_hi(sarg3_q[15:12]) + (2*WGT_W)'(32768);
  assign re_p2 = re4_q * exp_lo(rlo4_q) + (2*WGT_W)'(32768);
  assign se_p2 = se4_q * exp_lo(slo4_q) + (2*WGT_W)'(32768);
  assign w_p   = re5_q * se5_q + (2*WGT_W)'(32768);

  assign sts_o.busy = |v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q        <= '0;
      ctr_pend_q <= 1'b0;
    end else begin
      v_q        <= {v_q[6:1], cmd_i.issue};
      ctr_pend_q <= cmd_i.rd_centre;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctr_pend_q) centre_q <= rd_q;
    dist1_q <= dist2;
    // diff squared and spatial argument
    dsq2_q  <= diff * diff;
    sarg2_q <= dist1_q * cfg_i.spatial_coef;
    val2_q  <= rd_q;
    // range argument, Q.24 down to Q.16
    rarg3_q <= rprod[RP_W-1:8];
    sarg3_q <= sarg2_q;
    val3_q  <= val2_q;
    // exp: integer times high fraction
    rsat4_q <= (rarg3_q[RA_W-1:16] >= (RA_W-16)'(12));
    ssat4_q <= (sarg3_q[SA_W-1:16] >= (SA_W-16)'(12));
    re4_q   <= re_p1[WGT_W+15:16];
    se4_q   <= se_p1[WGT_W+15:16];
    rlo4_q  <= rarg3_q[11:8];
    slo4_q  <= sarg3_q[11:8];
    val4_q  <= val3_q;
    // exp: low fraction
    re5_q   <= rsat4_q ? '0 : re_p2[WGT_W+15:16];
    se5_q   <= ssat4_q ? '0 : se_p2[WGT_W+15:16];
    val5_q  <= val4_q;
    // combined weight
    w6_q    <= w_p[WGT_W+15:16];
    val6_q  <= val5_q;
    // weighted sample
    wv7_q   <= w6_q * val6_q;
    w7_q    <= w6_q;
    if (cmd_i.walk_init) begin
      num_q <= '0;
      den_q <= '0;
    end else if (v_q[7]) begin
      num_q <= num_q + NUM_W'(wv7_q);
      den_q <= den_q + DEN_W'(w7_q);
    end
  end

  // Restoring divider, one quotient bit per step; quotient fits V bits
  logic [NUM_W-1:0] dividend;
  logic [DEN_W-1:0] rem_q;
  logic [V-1:0]     nlo_q, quo_q, res_q;
  logic [DEN_W:0]   trial;
  logic             take;

  assign dividend = num_q + NUM_W'(den_q >> 1);
  assign trial    = {rem_q, nlo_q[V-1]};
  assign take     = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= dividend[NUM_W-1:V];
      nlo_q <= dividend[V-1:0];
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= take ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      nlo_q <= nlo_q << 1;
      quo_q <= {quo_q[V-2:0], take};
    end
    if (cmd_i.res_ld) begin
      res_q <= (den_q == '0) ? centre_q : quo_q;
    end
  end

  assign filtered_value_o = FIELD_W'(res_q);

endmodule

// File: hw/rtl/bf3_ctrl.sv
// ----------------------------------------------------------------------------
// bf3_ctrl
// Sequencer of one request: a load writes its voxel; a filter runs remainder,
// centre read, back-off, walk, drain, divide and result hand-off.
// ----------------------------------------------------------------------------
module bf3_ctrl import bf3_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  input  logic in_func_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOD   = 4'd1;
  localparam logic [3:0] S_CTR   = 4'd2;
  localparam logic [3:0] S_BACK  = 4'd3;
  localparam logic [3:0] S_INIT  = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_DRAIN = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.wr_en = accept & ~in_func_i;
        cmd_o.start = accept & in_func_i;
        cnt_d       = '0;
        if (accept && in_func_i) state_d = S_MOD;
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(COORD_W - 1)) state_d = S_CTR;
      end
      S_CTR: begin
        cmd_o.rd_centre = 1'b1;
        cnt_d           = '0;
        state_d         = (cfg_i.half != '0) ? S_BACK : S_INIT;
      end
      S_BACK: begin
        cmd_o.back_step = 1'b1;
        cnt_d           = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(cfg_i.half - DIAM_W'(1))) state_d = S_INIT;
      end
      S_INIT: begin
        cmd_o.walk_init = 1'b1;
        state_d         = (cfg_i.diam != '0) ? S_WALK : S_DRAIN;
      end
      S_WALK: begin
        cmd_o.issue = 1'b1;
        if (sts_i.walk_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        cnt_d = '0;
        if (!sts_i.busy) begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(VALUE_BITS - 1)) state_d = S_FIN;
      end
      S_FIN: begin
        // hold the quotient until the result register frees up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_div_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> !sts_i.busy)
    else $error("divide started with samples still in the weight pipeline");

  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == S_FIN && state_q == S_IDLE) |-> out_valid_q)
    else $error("filter result dropped on the way out");

  a_mod_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |=> (state_q == S_MOD || state_q == S_CTR))
    else $error("remainder phase left early");

  a_walk_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && sts_i.walk_last) |=> (state_q == S_DRAIN && sts_i.busy))
    else $error("window walk ended without pending samples");

endmodule

// File: tb/tb_bilateral_filter_3d_unit.sv
// ----------------------------------------------------------------------------
// tb_bilateral_filter_3d_unit
// Self-checking bench for the 3-D bilateral filter. Each phase but the first
// programs the registers over APB and reads them back. It then loads a block of voxels
// around the wrap seams and sends a mix of load and filter requests. A
// predictor works out every filtered value as requests are queued. The
// monitor checks each result in order.
// ----------------------------------------------------------------------------
module tb_bilateral_filter_3d_unit;
  import bf3_pkg::*;

  localparam int IDLE_LIMIT  = 20000;  // cycles with no transfer at all
  localparam int DRAIN_WAIT  = 400;    // longest filter walk plus divide
  localparam int VOL_DEPTH   = MAX_DIM * MAX_DIM * MAX_DIM;

  localparam longint unsigned EXP_INT_T[12] = '{
    65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
  localparam longint unsigned EXP_HI_T[16] = '{
    65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
    39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
  localparam longint unsigned EXP_LO_T[16] = '{
    65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
    63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

  typedef struct {
    logic               func;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [FIELD_W-1:0] value;
  } voxel_req_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  bf3_in_if  in_bus ();
  bf3_out_if out_bus ();

  bilateral_filter_3d_unit uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the configuration and of the voxel store
  int unsigned       cfg_diam, cfg_range, cfg_spatial, cfg_sx, cfg_sy, cfg_sz;
  logic [15:0]       vol_copy [VOL_DEPTH];
  bit                vol_written [VOL_DEPTH];

  voxel_req_t        pending_reqs[$];
  logic [FIELD_W-1:0] filtered_expected[$];

  int  error_count;
  int  results_seen;
  int  loads_sent;
  int  filters_sent;
  int  phases_run;
  int  cycle_count;
  int  idle_cycles;
  bit  hold_output;
  bit  in_accepted;

  // Clock: period 2
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int eff_extent(input int unsigned s);
    if (s == 0) return 1;
    if (s > MAX_DIM) return MAX_DIM;
    return int'(s);
  endfunction

  function automatic int wrap_coord(input int v, input int s);
    int r;
    r = v % s;
    if (r < 0) r += s;
    return r;
  endfunction

  function automatic int vox_index(input int x, input int y, input int z);
    return (x * MAX_DIM + y) * MAX_DIM + z;
  endfunction

  // Q.16 argument to an exp(-t) weight through the three lookup tables
  function automatic longint unsigned neg_exp_q16(input longint unsigned t);
    longint unsigned e;
    if (t >= (64'd12 << 16)) return 0;
    e = (EXP_INT_T[(t >> 16) & 15] * EXP_HI_T[(t >> 12) & 15] + 32768) >> 16;
    e = (e * EXP_LO_T[(t >> 8) & 15] + 32768) >> 16;
    return e;
  endfunction

  // True when every voxel the window of this request touches has been loaded
  function automatic bit window_loaded(input int px, input int py, input int pz);
    int sx, sy, sz, cx, cy, cz, d, hl;
    sx = eff_extent(cfg_sx);
    sy = eff_extent(cfg_sy);
    sz = eff_extent(cfg_sz);
    cx = px % sx;
    cy = py % sy;
    cz = pz % sz;
    d  = (cfg_diam > MAX_DIAMETER) ? MAX_DIAMETER : int'(cfg_diam);
    hl = d / 2;
    if (!vol_written[vox_index(cx, cy, cz)]) return 0;
    for (int i = 0; i < d; i++)
      for (int j = 0; j < d; j++)
        for (int k = 0; k < d; k++)
          if (!vol_written[vox_index(wrap_coord(cx + i - hl, sx),
                                     wrap_coord(cy + j - hl, sy),
                                     wrap_coord(cz + k - hl, sz))]) return 0;
    return 1;
  endfunction

  function automatic logic [FIELD_W-1:0] predict_filtered(input int px, input int py,
                                                          input int pz);
    int sx, sy, sz, cx, cy, cz, d, hl, ox, oy, oz;
    longint unsigned num, den, centre, v, diff, dist2, er, es, w;
    sx = eff_extent(cfg_sx);
    sy = eff_extent(cfg_sy);
    sz = eff_extent(cfg_sz);
    cx = px % sx;
    cy = py % sy;
    cz = pz % sz;
    centre = vol_copy[vox_index(cx, cy, cz)];
    d  = (cfg_diam > MAX_DIAMETER) ? MAX_DIAMETER : int'(cfg_diam);
    hl = d / 2;
    num = 0;
    den = 0;
    for (int i = 0; i < d; i++)
      for (int j = 0; j < d; j++)
        for (int k = 0; k < d; k++) begin
          ox = i - hl;
          oy = j - hl;
          oz = k - hl;
          v = vol_copy[vox_index(wrap_coord(cx + ox, sx), wrap_coord(cy + oy, sy),
                                 wrap_coord(cz + oz, sz))];
          diff  = (v >= centre) ? v - centre : centre - v;
          dist2 = longint'(ox * ox + oy * oy + oz * oz);
          er = neg_exp_q16((diff * diff * cfg_range) >> 8);
          es = neg_exp_q16(dist2 * cfg_spatial);
          w  = (er * es + 32768) >> 16;
          num += w * v;
          den += w;
        end
    if (den == 0) return centre[FIELD_W-1:0];
    return FIELD_W'((num + den / 2) / den);
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders: update the store mirror and the expected results
  // ---------------------------------------------------------------------------
  function automatic logic [FIELD_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  task automatic queue_load(input int x, input int y, input int z, input logic [15:0] val);
    voxel_req_t r;
    r.func  = 1'b0;
    r.x     = COORD_W'(x);
    r.y     = COORD_W'(y);
    r.z     = COORD_W'(z);
    r.value = val;
    vol_copy[vox_index(r.x, r.y, r.z)]    = val;
    vol_written[vox_index(r.x, r.y, r.z)] = 1'b1;
    pending_reqs.push_back(r);
    loads_sent++;
  endtask

  // Fall back to a centre sitting on the preloaded seam when the window is
  // not fully loaded; a multiple of the extent still tests the modulo.
  task automatic queue_filter(input int x, input int y, input int z);
    voxel_req_t r;
    int sx, sy, sz;
    if (!window_loaded(x, y, z)) begin
      sx = eff_extent(cfg_sx);
      sy = eff_extent(cfg_sy);
      sz = eff_extent(cfg_sz);
      x = sx * $urandom_range(0, 31 / sx);
      y = sy * $urandom_range(0, 31 / sy);
      z = sz * $urandom_range(0, 31 / sz);
    end
    r.func  = 1'b1;
    r.x     = COORD_W'(x);
    r.y     = COORD_W'(y);
    r.z     = COORD_W'(z);
    r.value = FIELD_W'($urandom);
    filtered_expected.push_back(predict_filtered(x, y, z));
    pending_reqs.push_back(r);
    filters_sent++;
  endtask

  // Load every voxel within half a window of the origin seam on each axis
  task automatic preload_seams();
    bit done [VOL_DEPTH];
    int sx, sy, sz, x, y, z, hl;
    sx = eff_extent(cfg_sx);
    sy = eff_extent(cfg_sy);
    sz = eff_extent(cfg_sz);
    hl = ((cfg_diam > MAX_DIAMETER) ? MAX_DIAMETER : int'(cfg_diam)) / 2;
    for (int i = -hl; i <= hl; i++)
      for (int j = -hl; j <= hl; j++)
        for (int k = -hl; k <= hl; k++) begin
          x = wrap_coord(i, sx);
          y = wrap_coord(j, sy);
          z = wrap_coord(k, sz);
          if (!done[vox_index(x, y, z)]) begin
            done[vox_index(x, y, z)] = 1'b1;
            queue_load(x, y, z, pick_value());
          end
        end
  endtask

  task automatic queue_random(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 3)
        queue_load($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                   pick_value());
      else
        queue_filter($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
    end
  endtask

  // ---------------------------------------------------------------------------
  // APB access
  // ---------------------------------------------------------------------------
  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    logic [31:0] mask;
    case (idx)
      REG_DIAMETER: begin
        mask = 32'h7;
        cfg_diam = val & mask;
      end
      REG_RANGE: begin
        mask = 32'hFF_FFFF;
        cfg_range = val & mask;
      end
      REG_SPATIAL: begin
        mask = 32'hFF_FFFF;
        cfg_spatial = val & mask;
      end
      REG_SIZE_X: begin
        mask = 32'h3F;
        cfg_sx = val & mask;
      end
      REG_SIZE_Y: begin
        mask = 32'h3F;
        cfg_sy = val & mask;
      end
      default: begin
        mask = 32'h3F;
        cfg_sz = val & mask;
      end
    endcase
    // Write: setup then access
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= val & mask;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    // Read back the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== (val & mask)) report_mismatch("register readback", prdata, val & mask);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold the sender until all requests are in and all results are out
  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_bus.valid && filtered_expected.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic program_regs(input int unsigned d, input int unsigned rc,
                              input int unsigned sc, input int unsigned sx,
                              input int unsigned sy, input int unsigned sz);
    reg_write(REG_DIAMETER, d);
    reg_write(REG_RANGE, rc);
    reg_write(REG_SPATIAL, sc);
    reg_write(REG_SIZE_X, sx);
    reg_write(REG_SIZE_Y, sy);
    reg_write(REG_SIZE_Z, sz);
  endtask

  // One phase: preload, a few directed corner filters, then random traffic
  task automatic run_phase(input int count);
    preload_seams();
    queue_filter(0, 0, 0);
    queue_filter(31, 31, 31);
    queue_filter(31, 0, 31);
    queue_random(count);
    phases_run++;
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present requests at the falling edge
  // ---------------------------------------------------------------------------
  function automatic bit quiet_window();
    return cycle_count >= 10000 && cycle_count < 20000;
  endfunction

  always @(posedge clk) begin
    in_accepted <= in_bus.valid && in_bus.ready;
    cycle_count <= cycle_count + 1;
  end

  always @(negedge clk) begin
    if (rst_n && (!in_bus.valid || in_accepted)) begin
      if (pending_reqs.size() > 0 && (quiet_window() || $urandom_range(0, 99) >= 8)) begin
        in_bus.valid       <= 1'b1;
        in_bus.func        <= pending_reqs[0].func;
        in_bus.pos_x       <= pending_reqs[0].x;
        in_bus.pos_y       <= pending_reqs[0].y;
        in_bus.pos_z       <= pending_reqs[0].z;
        in_bus.voxel_value <= pending_reqs[0].value;
        void'(pending_reqs.pop_front());
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver ready, with random stalls and one long hold-off
  always @(negedge clk) begin
    out_bus.ready <= !hold_output && (quiet_window() || $urandom_range(0, 99) >= 8);
  end

  initial begin
    hold_output = 1'b0;
    wait (cycle_count >= 5000 && filtered_expected.size() > 1);
    @(negedge clk);
    hold_output = 1'b1;
    repeat (1500) @(posedge clk);
    @(negedge clk);
    hold_output = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (filtered_expected.size() == 0) begin
        report_mismatch("unexpected result", out_bus.filtered_value, -1);
      end else begin
        if (out_bus.filtered_value !== filtered_expected[0])
          report_mismatch("filtered_value", out_bus.filtered_value, filtered_expected[0]);
        void'(filtered_expected.pop_front());
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    error_count  = 0;
    results_seen = 0;
    loads_sent   = 0;
    filters_sent = 0;
    phases_run   = 0;
    cycle_count  = 0;
    idle_cycles  = 0;
    in_accepted  = 1'b0;
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_bus.valid       = 1'b0;
    in_bus.func        = 1'b0;
    in_bus.pos_x       = '0;
    in_bus.pos_y       = '0;
    in_bus.pos_z       = '0;
    in_bus.voxel_value = '0;
    out_bus.ready      = 1'b0;
    cfg_diam    = RST_DIAMETER;
    cfg_range   = RST_RANGE;
    cfg_spatial = RST_SPATIAL;
    cfg_sx      = RST_SIZE;
    cfg_sy      = RST_SIZE;
    cfg_sz      = RST_SIZE;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset defaults, full 32-voxel extents
    run_phase(30);
    // Widest window, flat weights, extents below the window so it wraps
    program_regs(7, 0, 0, 3, 4, 5);
    run_phase(30);
    // Single voxel volume, strongest coefficients
    program_regs(1, 24'hFF_FFFF, 24'hFF_FFFF, 1, 1, 1);
    run_phase(20);
    // Empty window: the centre voxel comes back
    program_regs(0, $urandom, $urandom, 32, 2, 3);
    run_phase(20);
    // Even window, mixed extents
    program_regs(4, 1000, 20000, 3, 32, 4);
    run_phase(30);
    // Zero and oversize extents saturate
    program_regs(7, 24'hFF_FFFF, 0, 0, 63, 7);
    run_phase(30);
    // Random settings on small volumes
    for (int p = 0; p < 3; p++) begin
      program_regs($urandom_range(1, 7), $urandom_range(0, 4096),
                   $urandom_range(0, 24'hFF_FFFF),
                   $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4));
      run_phase(25);
    end

    $display("Covered %0d phases: %0d loads and %0d filters, %0d results checked",
             phases_run, loads_sent, filters_sent, results_seen);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/bf3_pkg.sv
hw/rtl/bf3_in_if.sv
hw/rtl/bf3_out_if.sv
hw/rtl/bf3_regs.sv
hw/rtl/bf3_dp.sv
hw/rtl/bf3_ctrl.sv
hw/rtl/bilateral_filter_3d_unit.sv
tb/tb_bilateral_filter_3d_unit.sv
